// ----- rtl/rde_pkg.sv -----
package rde_pkg;

  // Sizing of the record format
  localparam int MAX_ATTRS  = 16;
  localparam int MAX_RECORD = 4096;

  localparam int FIDX_W = $clog2(MAX_ATTRS + 1);
  localparam int NIDX_W = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
  localparam int OFS_W  = $clog2(MAX_RECORD + 1);

  // Fixed field widths
  localparam int ACNT_W     = 5;
  localparam int TMASK_W    = 16;
  localparam int KIND_W     = 2;
  localparam int POS_W      = 12;
  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_MASK  = CFG_IDX_W'(1);

  // Write kinds
  localparam logic [KIND_W-1:0] KIND_HEADER = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_DATA   = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_ENTRY  = KIND_W'(2);

  // Controller commands
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ABSORB,
    OP_ENTRY,
    OP_WALK,
    OP_FAIL,
    OP_FLUSH
  } op_t;

  // What follows once an input byte has been absorbed
  typedef enum logic [2:0] {
    AFT_DONE,
    AFT_FLUSH,
    AFT_ENTRY,
    AFT_WALK,
    AFT_FAIL
  } after_t;

  // Outcome of one field walk step
  typedef enum logic [1:0] {
    WK_NULL,
    WK_STOP,
    WK_FAIL,
    WK_FINISH
  } walk_t;

  typedef struct packed {
    after_t after;
    walk_t  walk;
    logic   shift_ok;
  } stat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    logic              done;
    logic [OFS_W-1:0]  total;
    logic              err;
    logic              last;
  } res_t;

endpackage

// ----- rtl/rde_ctrl.sv -----
module rde_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rde_pkg::stat_t stat,
  output rde_pkg::op_t   op
);
  import rde_pkg::*;

  typedef enum logic [2:0] {
    ST_IN,
    ST_ENTRY,
    ST_WALK,
    ST_FAIL,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_ABSORB;
          case (stat.after)
            AFT_FLUSH: state_nxt = ST_FLUSH;
            AFT_ENTRY: state_nxt = ST_ENTRY;
            AFT_WALK:  state_nxt = ST_WALK;
            AFT_FAIL:  state_nxt = ST_FAIL;
            default:   state_nxt = ST_IN;
          endcase
        end
      end
      ST_ENTRY: begin
        if (stat.shift_ok) begin
          op        = OP_ENTRY;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat.shift_ok) begin
          op = OP_WALK;
          case (stat.walk)
            WK_NULL: state_nxt = ST_WALK;
            WK_FAIL: state_nxt = ST_FAIL;
            default: state_nxt = ST_FLUSH;
          endcase
        end
      end
      ST_FAIL: begin
        if (stat.shift_ok) begin
          op        = OP_FAIL;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (stat.shift_ok) begin
          op        = OP_FLUSH;
          state_nxt = ST_IN;
        end
      end
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/rde_dp.sv -----
module rde_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [rde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rde_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                       raw_byte,
  input  rde_pkg::op_t                     op,
  output rde_pkg::stat_t                   stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output rde_pkg::res_t                    out_res
);
  import rde_pkg::*;

  typedef enum logic [1:0] {
    PH_BITMAP,
    PH_LENGTH,
    PH_BYTES
  } phase_t;

  // config
  logic [ACNT_W-1:0]  attr_count_r, attr_count_nxt;
  logic [TMASK_W-1:0] text_mask_r, text_mask_nxt;

  // record walk state
  phase_t              phase_r, phase_nxt;
  logic [FIDX_W-1:0]   fidx_r, fidx_nxt;
  logic [MAX_ATTRS-1:0] null_r, null_nxt;
  logic [2:0]          sub_r, sub_nxt;
  logic [OFS_W-1:0]    ofs_r, ofs_nxt;
  logic [23:0]         len_r, len_nxt;
  logic [OFS_W-1:0]    left_r, left_nxt;

  // hold stage and output stage
  res_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  res_t out_r, out_nxt;
  logic out_v_r, out_v_nxt;

  logic [FIDX_W-1:0]   n_cnt;
  logic [3:0]          nbytes;
  logic [3:0]          sub_inc;
  logic                first;
  logic                bm_done;
  logic [MAX_ATTRS-1:0] null_new;
  logic [OFS_W-1:0]    room;
  logic                fits1;
  logic                fits4;
  logic [31:0]         len_full;
  logic                len_zero;
  logic                len_over;
  logic                len_final;
  logic [OFS_W-1:0]    left_dec;
  logic                walk_text;
  logic                prod;
  res_t                prod_res;

  // effective attribute count
  always_comb begin
    if (attr_count_r == '0) begin
      n_cnt = FIDX_W'(1);
    end else if (32'(attr_count_r) > MAX_ATTRS) begin
      n_cnt = FIDX_W'(MAX_ATTRS);
    end else begin
      n_cnt = FIDX_W'(attr_count_r);
    end
  end

  assign nbytes   = 4'(({1'b0, n_cnt} + (FIDX_W + 1)'(7)) >> 3);
  assign sub_inc  = {1'b0, sub_r} + 4'd1;
  assign first    = (sub_r == 3'd0);
  assign bm_done  = (sub_inc >= nbytes);
  assign room     = OFS_W'(MAX_RECORD) - ofs_r;
  assign fits1    = (room != '0);
  assign fits4    = (room >= OFS_W'(4));
  assign len_full = {raw_byte, len_r};
  assign len_zero = (len_full == 32'd0);
  assign len_over = (len_full > 32'(room));
  assign len_final = (sub_inc >= 4'd4);
  assign left_dec = (left_r != '0) ? left_r - OFS_W'(1) : '0;
  assign walk_text = (32'(fidx_r) < TMASK_W) && text_mask_r[4'(fidx_r)];

  // bitmap byte merge, MSB first
  always_comb begin
    for (int j = 0; j < MAX_ATTRS; j++) begin
      null_new[j] = (!first && null_r[j]) ||
                    ((sub_r == 3'(j / 8)) && raw_byte[7 - (j % 8)]);
    end
  end

  // status toward the controller
  always_comb begin
    case (phase_r)
      PH_LENGTH: begin
        if (!len_final) begin
          stat.after = AFT_DONE;
        end else if (len_zero) begin
          stat.after = fits1 ? AFT_ENTRY : AFT_FAIL;
        end else begin
          stat.after = len_over ? AFT_FAIL : AFT_DONE;
        end
      end
      PH_BYTES: stat.after = (left_dec == '0) ? AFT_ENTRY : AFT_FLUSH;
      default: begin
        if (bm_done) begin
          stat.after = AFT_WALK;
        end else begin
          stat.after = first ? AFT_FLUSH : AFT_DONE;
        end
      end
    endcase

    if (fidx_r >= n_cnt) begin
      stat.walk = WK_FINISH;
    end else if (null_r[NIDX_W'(fidx_r)]) begin
      stat.walk = WK_NULL;
    end else if (walk_text || fits4) begin
      stat.walk = WK_STOP;
    end else begin
      stat.walk = WK_FAIL;
    end

    stat.shift_ok = !pend_v_r || !out_v_r || out_ready;
  end

  always_comb begin
    attr_count_nxt = attr_count_r;
    text_mask_nxt  = text_mask_r;
    phase_nxt      = phase_r;
    fidx_nxt       = fidx_r;
    null_nxt       = null_r;
    sub_nxt        = sub_r;
    ofs_nxt        = ofs_r;
    len_nxt        = len_r;
    left_nxt       = left_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    out_nxt        = out_r;
    out_v_nxt      = out_v_r && !out_ready;
    prod           = 1'b0;
    prod_res       = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_ATTR_COUNT: attr_count_nxt = cfg_data[ACNT_W-1:0];
        CFG_TEXT_MASK:  text_mask_nxt  = cfg_data[TMASK_W-1:0];
        default: ;
      endcase
    end

    case (op)
      OP_ABSORB: begin
        case (phase_r)
          PH_LENGTH: begin
            sub_nxt = sub_inc[2:0];
            case (sub_r[1:0])
              2'd0:    len_nxt[7:0]   = raw_byte;
              2'd1:    len_nxt[15:8]  = raw_byte;
              2'd2:    len_nxt[23:16] = raw_byte;
              default: ;
            endcase
            if (len_final) begin
              sub_nxt = 3'd0;
              if (len_zero) begin
                if (fits1) begin
                  // empty text keeps one pad byte
                  prod           = 1'b1;
                  prod_res.kind  = KIND_DATA;
                  prod_res.pos   = POS_W'(ofs_r);
                  ofs_nxt        = ofs_r + OFS_W'(1);
                end
              end else if (!len_over) begin
                left_nxt  = OFS_W'(len_full);
                phase_nxt = PH_BYTES;
              end
            end
          end
          PH_BYTES: begin
            prod           = 1'b1;
            prod_res.kind  = KIND_DATA;
            prod_res.pos   = POS_W'(ofs_r);
            prod_res.value = VAL_W'(raw_byte);
            ofs_nxt        = ofs_r + OFS_W'(1);
            left_nxt       = left_dec;
          end
          default: begin
            if (first) begin
              ofs_nxt        = OFS_W'({n_cnt, 1'b0}) + OFS_W'(1);
              fidx_nxt       = '0;
              prod           = 1'b1;
              prod_res.kind  = KIND_HEADER;
              prod_res.value = VAL_W'(1);
            end
            null_nxt = null_new;
            sub_nxt  = bm_done ? 3'd0 : sub_inc[2:0];
          end
        endcase
      end
      OP_ENTRY: begin
        prod           = 1'b1;
        prod_res.kind  = KIND_ENTRY;
        prod_res.pos   = POS_W'({fidx_r, 1'b0}) + POS_W'(1);
        prod_res.value = VAL_W'(ofs_r);
        fidx_nxt       = fidx_r + FIDX_W'(1);
      end
      OP_WALK: begin
        case (stat.walk)
          WK_FINISH: begin
            pend_nxt.done  = 1'b1;
            pend_nxt.total = ofs_r;
            phase_nxt      = PH_BITMAP;
            sub_nxt        = 3'd0;
            fidx_nxt       = '0;
            null_nxt       = '0;
          end
          WK_NULL: begin
            prod           = 1'b1;
            prod_res.kind  = KIND_ENTRY;
            prod_res.pos   = POS_W'({fidx_r, 1'b0}) + POS_W'(1);
            prod_res.value = VAL_W'(ofs_r);
            fidx_nxt       = fidx_r + FIDX_W'(1);
          end
          WK_STOP: begin
            if (walk_text) begin
              phase_nxt = PH_LENGTH;
              sub_nxt   = 3'd0;
            end else begin
              phase_nxt = PH_BYTES;
              left_nxt  = OFS_W'(4);
            end
          end
          default: ;
        endcase
      end
      OP_FAIL: begin
        // overrun: rewrite header, close record with error
        prod           = 1'b1;
        prod_res.kind  = KIND_HEADER;
        prod_res.value = VAL_W'(1);
        prod_res.done  = 1'b1;
        prod_res.err   = 1'b1;
        phase_nxt      = PH_BITMAP;
        sub_nxt        = 3'd0;
        fidx_nxt       = '0;
        null_nxt       = '0;
      end
      OP_FLUSH: begin
        if (pend_v_r) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
        end
      end
      default: ;
    endcase

    // a new result pushes the held one out
    if (prod) begin
      if (pend_v_r) begin
        out_nxt   = pend_r;
        out_v_nxt = 1'b1;
      end
      pend_nxt   = prod_res;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_count_r <= ACNT_W'(1);
      text_mask_r  <= '0;
      phase_r      <= PH_BITMAP;
      fidx_r       <= '0;
      null_r       <= '0;
      sub_r        <= 3'd0;
      ofs_r        <= '0;
      pend_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      attr_count_r <= attr_count_nxt;
      text_mask_r  <= text_mask_nxt;
      phase_r      <= phase_nxt;
      fidx_r       <= fidx_nxt;
      null_r       <= null_nxt;
      sub_r        <= sub_nxt;
      ofs_r        <= ofs_nxt;
      pend_v_r     <= pend_v_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    left_r <= left_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

// ----- rtl/record_directory_encoder.sv -----
// Record directory encoder. Raw record bytes come in one per transaction on
// the in_ channel: a null bitmap of ceil(n/8) bytes (MSB first), then each
// non-null field (fixed fields 4 bytes, text fields a 4-byte little-endian
// length plus that many bytes). Each out_ transaction is one write of the
// stored form: the header byte, a data byte, or a 16-bit directory end
// offset. run_last marks the final write caused by an input byte;
// record_done marks the final write of a record and carries record_size, or
// overrun_error when a field would not fit in MAX_RECORD bytes (record_size
// is then zero). Timing: every write passes through a one-entry hold stage
// and then the output register, one write per cycle unless stalled. A byte
// that causes no write is only absorbed; a byte whose only write is a data
// or header byte is absorbed, then flushed. A byte that ends a field, the
// bitmap or the record is absorbed, then takes one step per directory
// entry, a final walk step, a fail step on overrun, and a flush. A new byte
// is accepted only once the previous byte's steps end. Output backpressure
// only stalls the sequencer when both the hold stage and the output
// register are full. Configuration writes are always accepted (cfg_ready
// is tied high) and should only be issued while the block is idle.
module record_directory_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rde_pkg::CFG_DATA_W-1:0]  cfg_data,
  // raw record bytes
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_raw_byte,
  // stored-form writes
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rde_pkg::KIND_W-1:0]      out_write_kind,
  output logic [rde_pkg::POS_W-1:0]       out_write_position,
  output logic [rde_pkg::VAL_W-1:0]       out_write_value,
  output logic                            out_record_done,
  output logic [rde_pkg::OFS_W-1:0]       out_record_size,
  output logic                            out_overrun_error,
  output logic                            out_run_last
);
  import rde_pkg::*;

  op_t   op;
  stat_t stat;
  res_t  out_res;

  assign cfg_ready = 1'b1;

  // sequencer: one byte absorbed, then entries / walk / close, then flush
  rde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // record state, hold stage and output register
  rde_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .raw_byte  (in_raw_byte),
    .op        (op),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_write_kind     = out_res.kind;
  assign out_write_position = out_res.pos;
  assign out_write_value    = out_res.value;
  assign out_record_done    = out_res.done;
  assign out_record_size    = out_res.total;
  assign out_overrun_error  = out_res.err;
  assign out_run_last       = out_res.last;

  // an overrun closes the record with a zero size on the byte's last write
  a_overrun_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overrun_error |->
      out_record_done && out_run_last && (out_record_size == '0))
    else $error("overrun write not a closing write");

  // a clean close carries a nonzero size and ends the byte's writes
  a_done_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_done && !out_overrun_error |->
      out_run_last && (out_record_size != '0))
    else $error("record close without size");

  // the sequencer only steps when the hold stage can move
  a_step_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_ENTRY) || (op == OP_WALK) || (op == OP_FAIL) || (op == OP_FLUSH) |->
      stat.shift_ok)
    else $error("step issued while output blocked");

endmodule
